/* sv/ahmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ahmt_pkg;

  localparam int ANTENNAS = 512;
  localparam int ADDR_W = (ANTENNAS > 1) ? $clog2(ANTENNAS) : 1;
  localparam int IDX_W = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_EVAL = 2'd0;
  localparam logic [1:0] OP_MASK = 2'd1;
  localparam logic [1:0] OP_UNMASK = 2'd2;

  localparam logic [1:0] HS_HEALTHY = 2'd0;
  localparam logic [1:0] HS_DEAD = 2'd1;
  localparam logic [1:0] HS_SATURATED = 2'd2;
  localparam logic [1:0] HS_MANUAL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVIVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_EN = 3'd4;

  localparam logic [31:0] DEAD_LIMIT_RESET = 32'd3277;
  localparam logic [31:0] SAT_LIMIT_RESET = 32'd5242880;
  localparam logic [31:0] CLIP_LIMIT_RESET = 32'hFFFF_FFFF;
  localparam logic [15:0] REVIVAL_RESET = 16'd5;
  localparam logic [15:0] RUN_RESET = 16'd5;
  localparam logic [15:0] RUN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [31:0] dead_limit;
    logic [31:0] sat_limit;
    logic [31:0] clip_limit;
    logic [15:0] revival;
    logic        auto_en;
  } cfg_regs_t;

  typedef struct packed {
    logic        active;
    logic        manual_en;
    logic [15:0] run;
    logic [1:0]  status;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    active: 1'b1, manual_en: 1'b1, run: RUN_RESET, status: HS_HEALTHY
  };

endpackage
`default_nettype wire

/* sv/antenna_health_mask_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Per-antenna health tracker. Each request names an antenna and either
// evaluates one frame of its metrics (power, clip count) or sets or clears
// its manual mask; one result per request reports the antenna's active bit,
// status code, whether the active bit changed and its healthy-frame run.
// The table of entries lives in one single-port-read RAM. A request is first
// read from the RAM, then updated: the entry is written back and the output
// register loaded. A new request is taken only once the last one is through
// its update, and the update waits while a result is still not taken. The
// output register lets the next request enter while a result still waits.
// After reset a clearing pass writes the reset entry to every antenna,
// during which no request is taken; configuration writes are taken at any
// time, but change them only while no request is in flight. An index at or
// beyond ANTENNAS leaves the table alone and returns zero fields.
module antenna_health_mask_tracker
  import ahmt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [1:0]           opcode,
  input  wire logic [IDX_W-1:0]     antenna_index,
  input  wire logic [31:0]          power,
  input  wire logic [31:0]          clip_count,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [IDX_W-1:0]     antenna_out,
  output      logic                 active,
  output      logic [1:0]           health_status,
  output      logic                 active_toggled,
  output      logic [15:0]          healthy_run,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WORK  = 2'd2;

  logic [1:0]        state;
  logic [ADDR_W-1:0] clr_addr;

  // Request held across the RAM read.
  logic [1:0]        req_op;
  logic [IDX_W-1:0]  req_idx;
  logic [31:0]       req_power;
  logic [31:0]       req_clips;
  logic              req_in_range;

  cfg_regs_t         cfg;
  entry_t            rd_entry;
  entry_t            upd_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] in_addr;
  logic              in_range;
  logic              accept;
  logic              finish;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  // Finish a request once the output register is free or being drained.
  assign finish    = (state == S_WORK) && (!out_valid || out_ready);

  assign in_range = 32'(antenna_index) < 32'(ANTENNAS);
  assign in_addr  = ADDR_W'(antenna_index);
  assign rd_entry = entry_t'(ram_rdata);

  ahmt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  ahmt_eval u_eval (
    .opcode     (req_op),
    .power      (req_power),
    .clip_count (req_clips),
    .cfg        (cfg),
    .old_entry  (rd_entry),
    .new_entry  (upd_entry)
  );

  // Write port: reset entry during the clearing pass, updated entry otherwise.
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = ENTRY_RESET;
    end else begin
      ram_we    = finish && req_in_range;
      ram_waddr = ADDR_W'(req_idx);
      ram_wdata = upd_entry;
    end
  end

  ahmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ANTENNAS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Sequencer: clear, then alternate read and update.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == ADDR_W'(ANTENNAS - 1)) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + ADDR_W'(1);
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_WORK;
          end
        end
        S_WORK: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the request payload on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op       <= opcode;
      req_idx      <= antenna_index;
      req_power    <= power;
      req_clips    <= clip_count;
      req_in_range <= in_range;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      antenna_out <= req_idx;
      if (req_in_range) begin
        active         <= upd_entry.active;
        health_status  <= upd_entry.status;
        active_toggled <= upd_entry.active != rd_entry.active;
        healthy_run    <= upd_entry.run;
      end else begin
        // Drop out-of-range requests to a report of zero fields; the index is still echoed.
        active         <= 1'b0;
        health_status  <= HS_HEALTHY;
        active_toggled <= 1'b0;
        healthy_run    <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/ahmt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module ahmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/ahmt_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module ahmt_cfg
  import ahmt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [31:0]          wr_data,
  output      cfg_regs_t            regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dead_limit <= DEAD_LIMIT_RESET;
      regs.sat_limit  <= SAT_LIMIT_RESET;
      regs.clip_limit <= CLIP_LIMIT_RESET;
      regs.revival    <= REVIVAL_RESET;
      regs.auto_en    <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEAD_LIMIT: regs.dead_limit <= wr_data;
        REG_SAT_LIMIT:  regs.sat_limit  <= wr_data;
        REG_CLIP_LIMIT: regs.clip_limit <= wr_data;
        REG_REVIVAL:    regs.revival    <= wr_data[15:0];
        REG_AUTO_EN:    regs.auto_en    <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/ahmt_eval.sv */
`timescale 1ns / 1ps
`default_nettype none
module ahmt_eval
  import ahmt_pkg::*;
(
  input  wire logic        [1:0]  opcode,
  input  wire logic        [31:0] power,
  input  wire logic        [31:0] clip_count,
  input  wire cfg_regs_t          cfg,
  input  wire entry_t             old_entry,
  output      entry_t             new_entry
);

  logic        is_dead;
  logic        is_sat;
  logic [15:0] run_inc;

  assign is_dead = power <= cfg.dead_limit;
  assign is_sat  = (clip_count >= cfg.clip_limit) || (power >= cfg.sat_limit);
  assign run_inc = (old_entry.run != RUN_MAX) ? old_entry.run + 16'd1 : old_entry.run;

  always_comb begin
    new_entry = old_entry;
    case (opcode)
      OP_MASK: begin
        new_entry.manual_en = 1'b0;
        new_entry.active    = 1'b0;
        new_entry.status    = HS_MANUAL;
        new_entry.run       = '0;
      end
      OP_UNMASK: begin
        new_entry.manual_en = 1'b1;
        new_entry.active    = 1'b1;
        new_entry.status    = HS_HEALTHY;
        new_entry.run       = cfg.revival;
      end
      OP_EVAL: begin
        if (cfg.auto_en) begin
          if (!old_entry.manual_en) begin
            new_entry.status = HS_MANUAL;
            new_entry.run    = '0;
            new_entry.active = 1'b0;
          end else if (is_dead) begin
            new_entry.status = HS_DEAD;
            new_entry.run    = '0;
            new_entry.active = 1'b0;
          end else if (is_sat) begin
            new_entry.status = HS_SATURATED;
            new_entry.run    = '0;
            new_entry.active = 1'b0;
          end else begin
            new_entry.run = run_inc;
            // Masked antenna holds its status until the run is long enough.
            if (old_entry.active || run_inc >= cfg.revival) begin
              new_entry.status = HS_HEALTHY;
              new_entry.active = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* sv/ahmt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ahmt_checker
  import ahmt_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [IDX_W-1:0] antenna_out,
  input wire logic             active,
  input wire logic [1:0]       health_status,
  input wire logic [15:0]      healthy_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(antenna_out)
      && $stable(healthy_run))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in flight");

  a_active_healthy: assert property (@(posedge clk) disable iff (rst)
    out_valid && active |-> health_status == HS_HEALTHY)
    else $error("active antenna reported unhealthy");

  a_masked_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !active && healthy_run != 16'd0 |-> health_status != HS_HEALTHY)
    else $error("masked antenna reported healthy");

  a_manual_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && health_status == HS_MANUAL |-> !active && healthy_run == 16'd0)
    else $error("manual mask with active bit or run");

endmodule

bind antenna_health_mask_tracker ahmt_checker u_ahmt_checker (.*);
`default_nettype wire
